@@ hw/rtl/imu_moving_average_filter_defines.svh @@
// Assertion macros for the IMU moving-average filter.
// Included by the top level; expects clk and rst in scope.
`ifndef IMU_MOVING_AVERAGE_FILTER_DEFINES_SVH
`define IMU_MOVING_AVERAGE_FILTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define IMF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/imf_pkg.sv @@
// Shared types and constants of the IMU moving-average filter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package imf_pkg;

  localparam int NCH        = 7;   // channels per frame
  localparam int NRATE      = 3;   // rate channels at the low end of a frame
  localparam int SMP_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_OFFSET_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_OFFSET_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_OFFSET_Z = 2'd3;

  typedef struct packed {
    logic signed [SMP_W-1:0] accel_x_raw;
    logic signed [SMP_W-1:0] accel_y_raw;
    logic signed [SMP_W-1:0] accel_z_raw;
    logic signed [SMP_W-1:0] temperature_raw;
    logic signed [SMP_W-1:0] rate_x_raw;
    logic signed [SMP_W-1:0] rate_y_raw;
    logic signed [SMP_W-1:0] rate_z_raw;
  } imf_in_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] accel_x_out;
    logic signed [SMP_W-1:0] accel_y_out;
    logic signed [SMP_W-1:0] accel_z_out;
    logic signed [SMP_W-1:0] temperature_out;
    logic signed [SMP_W-1:0] rate_x_out;
    logic signed [SMP_W-1:0] rate_y_out;
    logic signed [SMP_W-1:0] rate_z_out;
  } imf_out_t;

  // Frame viewed as channels: the first field sits at index NCH-1.
  typedef logic [NCH-1:0][SMP_W-1:0] imf_vec_t;

endpackage

@@ hw/rtl/imf_cell.sv @@
// One window cell: holds a full frame of samples and takes its neighbor's
// frame on each shift. Depends on imf_pkg.
`timescale 1ns / 1ps

module imf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  imf_pkg::imf_in_t d,
  output imf_pkg::imf_in_t q
);
  import imf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

@@ hw/rtl/imf_scale.sv @@
// Divide a signed window sum by WINDOW, truncating toward zero, with a
// registered reciprocal multiply. Depends on imf_pkg.
`timescale 1ns / 1ps

module imf_scale #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 21
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic signed [SUM_W-1:0]         sum,
  output logic signed [imf_pkg::SMP_W-1:0] quot
);
  import imf_pkg::*;

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SH     = SUM_W + LOG_W;
  localparam int M_W    = SUM_W + 2;
  localparam int PROD_W = SUM_W + M_W;
  // ceil(2^SH / WINDOW); error below WINDOW keeps the floor exact for every magnitude
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  logic [SUM_W-1:0]  mag;
  logic              neg;
  logic [PROD_W-1:0] prod;
  logic [SMP_W:0]    qmag;
  logic [SMP_W:0]    qval;

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (load) begin
      neg  <= sum[SUM_W-1];
      prod <= PROD_W'(mag) * PROD_W'(RECIP[M_W-1:0]);
    end
  end

  assign qmag = prod[SH +: SMP_W+1];
  assign qval = neg ? (SMP_W+1)'(-qmag) : qmag;
  assign quot = qval[SMP_W-1:0];

endmodule

@@ hw/rtl/imu_moving_average_filter.sv @@
// IMU moving-average filter, top level.
// Uses imf_pkg, imf_cell, imf_scale and the assertion macro header.
//
// Usage: frames enter on sample/sample_valid; sample_stall high holds them off.
// Results leave on result/result_valid; drive result_stall high to hold one.
// A transfer happens at a rising edge with valid high and stall low.
// Each accepted frame gives one result through stages 1, 2 and 3, and
// one frame per cycle is taken as long as results are taken.
// The window is a row of WINDOW cells shifting one frame per enabled
// transfer; a running sum per channel adds the new sample and drops the one
// leaving the last cell, then a registered reciprocal multiply divides by
// WINDOW. With filtering off the raw frame passes and the window holds.
// Rate channels then have their offsets subtracted, saturated to 16 bits.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Reset (rst, synchronous) clears the window, sums, registers and pipeline.
// A stalled result holds; the pipeline fills behind it, then sample_stall
// rises after two more frames.
`timescale 1ns / 1ps
`include "imu_moving_average_filter_defines.svh"

module imu_moving_average_filter #(
  parameter int WINDOW = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  imf_pkg::imf_in_t                   sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output imf_pkg::imf_out_t                  result,
  input  logic                               cfg_we,
  input  logic [imf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [imf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import imf_pkg::*;

  localparam int LOG_W = $clog2(WINDOW);
  localparam int SUM_W = SMP_W + LOG_W + 1;

  // configuration
  logic                    filter_enable;
  logic signed [SMP_W-1:0] rate_offset [NRATE];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      for (int k = 0; k < NRATE; k++) begin
        rate_offset[k] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER_ENABLE: filter_enable  <= cfg_data[0];
        REG_RATE_OFFSET_X: rate_offset[0] <= cfg_data[SMP_W-1:0];
        REG_RATE_OFFSET_Y: rate_offset[1] <= cfg_data[SMP_W-1:0];
        REG_RATE_OFFSET_Z: rate_offset[2] <= cfg_data[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic accept, adv2, adv3, shift;
  logic s1_valid, s2_valid;
  logic s1_en, s2_en;
  imf_in_t s1_raw, s2_raw;

  assign adv3         = s2_valid && (!result_valid || !result_stall);
  assign adv2         = s1_valid && (!s2_valid || adv3);
  assign sample_stall = s1_valid && !adv2;
  assign accept       = sample_valid && !sample_stall;
  assign shift        = accept && filter_enable;

  // window cells: index 0 holds the oldest frame
  imf_in_t win [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    imf_in_t d;
    if (i == WINDOW - 1) begin : g_head
      assign d = sample;
    end else begin : g_link
      assign d = win[i+1];
    end
    imf_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (win[i])
    );
  end

  // running sums
  imf_vec_t new_vec, old_vec;
  logic [NCH-1:0][SUM_W-1:0] sum, sum_next;

  assign new_vec = imf_vec_t'(sample);
  assign old_vec = imf_vec_t'(win[0]);

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_next[c] = SUM_W'($signed(sum[c]) + SUM_W'($signed(new_vec[c]))
                           - SUM_W'($signed(old_vec[c])));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (shift) begin
      sum <= sum_next;
    end
  end

  // stage 1 holds the frame; the sum register already reflects it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv2) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_en  <= filter_enable;
      s1_raw <= sample;
    end
  end

  // stage 2: reciprocal multiply per channel
  logic signed [NCH-1:0][SMP_W-1:0] quot;

  for (genvar c = 0; c < NCH; c++) begin : g_scale
    imf_scale #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
    ) u_scale (
      .clk  (clk),
      .load (adv2),
      .sum  (sum[c]),
      .quot (quot[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= 1'b1;
    end else if (adv3) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_en  <= s1_en;
      s2_raw <= s1_raw;
    end
  end

  // stage 3: select, subtract rate offsets, saturate
  imf_vec_t raw_vec, val_vec, out_vec;
  logic signed [SMP_W:0] diff [NRATE];

  assign raw_vec = imf_vec_t'(s2_raw);

  always_comb begin
    val_vec = s2_en ? imf_vec_t'(quot) : raw_vec;
    out_vec = val_vec;
    for (int k = 0; k < NRATE; k++) begin
      diff[k] = (SMP_W+1)'($signed(val_vec[NRATE-1-k]))
              - (SMP_W+1)'(rate_offset[k]);
      if (diff[k][SMP_W] != diff[k][SMP_W-1]) begin
        out_vec[NRATE-1-k] = {diff[k][SMP_W], {(SMP_W-1){~diff[k][SMP_W]}}};
      end else begin
        out_vec[NRATE-1-k] = diff[k][SMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv3) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      result <= imf_out_t'(out_vec);
    end
  end

  `IMF_ASSERT_NEXT(a_sum_hold, accept && !filter_enable, $stable(sum), "sum moved while filter off")
  `IMF_ASSERT_SAME(a_full_stall, s1_valid && s2_valid && result_valid && result_stall, sample_stall, "full pipeline took a frame")
  `IMF_ASSERT_SAME(a_result_src, $rose(result_valid), $past(s2_valid), "result without stage 2 frame")

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the IMU moving-average filter: directed and random frames.
// Depends on imf_pkg and the imu_moving_average_filter top level.
`timescale 1ns / 1ps

module tb_top;
  import imf_pkg::*;

  localparam int WIN       = 10;
  localparam int MAX_CYC   = 400000;
  localparam int REPORT_N  = 10;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 100;
  localparam int QUIET_LEN = 50;

  logic      clk;
  logic      rst;
  logic      sample_valid;
  logic      sample_stall;
  imf_in_t   sample;
  logic      result_valid;
  logic      result_stall;
  imf_out_t  result;
  logic      cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  imu_moving_average_filter #(.WINDOW(WIN)) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Bench copy of the block state: history of frames, enable and rate offsets.
  imf_vec_t                     frame_hist [WIN];
  logic                         avg_on;
  logic [NRATE-1:0][SMP_W-1:0]  rate_off;   // index 2 is x, 0 is z

  imf_vec_t  predicted_out [$];
  bit        idle_on;
  int        frames_sent;
  int        frames_checked;
  int        errors;
  int        cycles;
  int        cfg_writes;

  string chan_name [NCH] = '{"rate_z", "rate_y", "rate_x", "temperature",
                             "accel_z", "accel_y", "accel_x"};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               predicted_out.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Average over the window when enabled, then subtract offsets with saturation.
  function automatic imf_vec_t average_frame(imf_vec_t f);
    imf_vec_t v;
    int       acc;
    int       i;
    int       c;
    v = f;
    if (avg_on) begin
      for (i = 0; i < WIN - 1; i++) frame_hist[i] = frame_hist[i + 1];
      frame_hist[WIN - 1] = f;
      for (c = 0; c < NCH; c++) begin
        acc = 0;
        for (i = 0; i < WIN; i++) acc += $signed(frame_hist[i][c]);
        v[c] = SMP_W'(acc / WIN);
      end
    end
    for (c = 0; c < NRATE; c++) begin
      acc = $signed(v[c]) - $signed(rate_off[c]);
      if (acc > 32767) acc = 32767;
      else if (acc < -32768) acc = -32768;
      v[c] = SMP_W'(acc);
    end
    return v;
  endfunction

  // Result checker: compare every transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    imf_vec_t got;
    imf_vec_t want;
    int       c;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_out.size() == 0) begin
        errors++;
        if (errors <= REPORT_N) $display("unexpected result %h", result);
      end else begin
        want = predicted_out.pop_front();
        got  = result;
        frames_checked++;
        for (c = 0; c < NCH; c++) begin
          if (got[c] !== want[c]) begin
            errors++;
            if (errors <= REPORT_N)
              $display("result %0d %s: expected %0d got %0d", frames_checked,
                       chan_name[c], $signed(want[c]), $signed(got[c]));
          end
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts while idling is enabled.
  initial begin : rx_idle
    result_stall = 1'b0;
    @(posedge clk);
    forever begin
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (idle_on) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  task automatic send_frame(input imf_in_t f);
    sample_valid <= 1'b1;
    sample       <= f;
    do @(posedge clk); while (sample_stall);
    predicted_out.push_back(average_frame(f));
    frames_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Drop valid, drain all outstanding results, then let the pipeline settle.
  task automatic drain;
    sample_valid <= 1'b0;
    while (predicted_out.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    case (idx)
      REG_FILTER_ENABLE: avg_on      = d[0];
      REG_RATE_OFFSET_X: rate_off[2] = d;
      REG_RATE_OFFSET_Y: rate_off[1] = d;
      REG_RATE_OFFSET_Z: rate_off[0] = d;
      default: ;
    endcase
  endtask

  function automatic logic [SMP_W-1:0] rand_sample;
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return r[SMP_W-1:0];
    endcase
  endfunction

  function automatic imf_in_t rand_frame;
    imf_vec_t v;
    int       c;
    for (c = 0; c < NCH; c++) v[c] = rand_sample();
    return v;
  endfunction

  function automatic imf_in_t fill_frame(input logic [SMP_W-1:0] s);
    imf_vec_t v;
    int       c;
    for (c = 0; c < NCH; c++) v[c] = s;
    return v;
  endfunction

  // Filter off, zero offsets: raw frames must pass unchanged.
  task automatic test_passthrough;
    imf_vec_t v;
    send_frame(fill_frame(16'h0000));
    send_frame(fill_frame(16'h7FFF));
    send_frame(fill_frame(16'h8000));
    send_frame(fill_frame(16'hFFFF));
    send_frame(fill_frame(16'h0001));
    v = {16'h5555, 16'hAAAA, 16'h1234, 16'hEDCB, 16'h8001, 16'h7FFE, 16'h00FF};
    send_frame(v);
    drain();
  endtask

  // Extreme offsets push the rate difference past both 16-bit limits.
  task automatic test_rate_saturation;
    write_reg(REG_RATE_OFFSET_X, 16'h7FFF);
    write_reg(REG_RATE_OFFSET_Y, 16'h8000);
    write_reg(REG_RATE_OFFSET_Z, 16'hFFFF);
    send_frame(fill_frame(16'h8000));
    send_frame(fill_frame(16'h7FFF));
    send_frame(fill_frame(16'h0000));
    send_frame(fill_frame(16'hC000));
    drain();
    write_reg(REG_RATE_OFFSET_X, 16'h0000);
    write_reg(REG_RATE_OFFSET_Y, 16'h0000);
    write_reg(REG_RATE_OFFSET_Z, 16'h0000);
  endtask

  // Enable through a wide value; cleared entries still count while filling.
  task automatic test_window_fill;
    int i;
    write_reg(REG_FILTER_ENABLE, 16'hFFFE);
    write_reg(REG_FILTER_ENABLE, 16'hFFFF);
    for (i = 0; i < 8; i++) send_frame(fill_frame(16'h7FFF));
    send_frame(fill_frame(16'h8000));
    send_frame(fill_frame(16'h8000));
    drain();
  endtask

  // Window holds its contents while filtering is off.
  task automatic test_toggle_hold;
    write_reg(REG_FILTER_ENABLE, 16'h0000);
    send_frame(rand_frame());
    send_frame(rand_frame());
    drain();
    write_reg(REG_FILTER_ENABLE, 16'h0001);
    send_frame(fill_frame(16'h0005));
    send_frame(rand_frame());
    drain();
  endtask

  function automatic logic [SMP_W-1:0] rand_offset;
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 200)) - 100);
      default: return r[SMP_W-1:0];
    endcase
  endfunction

  task automatic run_phase(input bit en, input int n);
    logic [31:0] d;
    int          i;
    d    = $urandom;
    d[0] = en;
    write_reg(REG_FILTER_ENABLE, d[CFG_DATA_W-1:0]);
    write_reg(REG_RATE_OFFSET_X, rand_offset());
    write_reg(REG_RATE_OFFSET_Y, rand_offset());
    write_reg(REG_RATE_OFFSET_Z, rand_offset());
    for (i = 0; i < n; i++) send_frame(rand_frame());
    drain();
  endtask

  // Random phases mostly alternate the filter mode, offsets changed between phases.
  task automatic test_random;
    int ph;
    for (ph = 0; ph < PHASES; ph++)
      run_phase((ph % 2 == 1) ^ ($urandom_range(0, 3) == 0), PHASE_LEN);
    idle_on = 1'b0;
    run_phase(1'b1, QUIET_LEN);
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    avg_on       = 1'b0;
    rate_off     = '0;
    idle_on      = 1'b1;
    for (int i = 0; i < WIN; i++) frame_hist[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_passthrough();
    test_rate_saturation();
    test_window_fill();
    test_toggle_hold();
    test_random();

    drain();
    $display("%0d frames sent, %0d results checked, %0d register writes",
             frames_sent, frames_checked, cfg_writes);
    $display("covered pass-through, averaging, window hold and rate saturation");
    if (errors == 0 && predicted_out.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
